// File: hdl/urm_pkg.sv
// Shared package for the ultrasonic range meter: phase and sequencer types,
// divider status word, fixed field widths, reset values and scale constants.
// No dependencies.
package urm_pkg;

  // default sizing handed down from the top level parameters
  localparam int COUNT_WIDTH_DEF   = 24;
  localparam int TRIGGER_TICKS_DEF = 10;

  // fixed field widths
  localparam int DIST_W     = 16;
  localparam int SPEED_W    = 10;
  localparam int TRIG_CNT_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // shared divider geometry: quotient bits and divisor width
  localparam int QUOT_W    = 17;
  localparam int DIVISOR_W = 11;

  // register reset values
  localparam logic [DIST_W-1:0]  MAX_DIST_RST = 16'd4000;
  localparam logic [SPEED_W-1:0] SPEED_RST    = 10'd343;

  // register index, taken from paddr bit 2
  localparam logic REG_MAX_DIST = 1'b0;
  localparam logic REG_SPEED    = 1'b1;

  // microseconds per millisecond, used to scale the echo wait limit
  localparam logic [SPEED_W-1:0]   US_PER_MS    = 10'd1000;
  // round trip and um-to-mm scaling: width_us * speed / 2000 gives mm
  localparam logic [DIVISOR_W-1:0] ROUND_TRIP_K = 11'd2000;

  // measurement phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2,
    PH_MEAS = 2'd3
  } phase_t;

  // per-tick sequencer
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_DIVGO,
    SQ_DIVWT,
    SQ_MUL,
    SQ_FIN
  } seq_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// File: hdl/urm_div.sv
// Shared restoring divider for the range meter, one quotient bit per cycle.
// Flags overflow when the quotient would not fit in QUOT_W bits.
// Depends on urm_pkg.
module urm_div #(
  parameter int DIVIDEND_W = 34
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [DIVIDEND_W-1:0]          dividend,
  input  logic [urm_pkg::DIVISOR_W-1:0]  divisor,
  output logic [urm_pkg::QUOT_W-1:0]     quot,
  output urm_pkg::div_stat_t             stat
);

  localparam int QW    = urm_pkg::QUOT_W;
  localparam int DVW   = urm_pkg::DIVISOR_W;
  localparam int REM_W = (DIVIDEND_W > DVW + QW) ? DIVIDEND_W : DVW + QW;
  localparam int CNT_W = $clog2(QW);

  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] sdiv;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ovf;
  logic             ge;

  // trial subtract against the shifted divisor
  assign ge = (rem >= sdiv);

  // load on start, then one quotient bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      ovf  <= (REM_W'(dividend) >= (REM_W'(divisor) << QW));
      cnt  <= CNT_W'(QW - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= REM_W'(dividend);
      sdiv <= REM_W'(divisor) << (QW - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - sdiv;
      end
      quot <= {quot[QW-2:0], ge};
      sdiv <= sdiv >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && (cnt == '0);
  assign stat.ovf  = ovf;

endmodule

// File: hdl/ultrasonic_range_meter_core.sv
// Ultrasonic range meter core: trigger pulse, echo wait with timeout, echo
// width measurement and mm conversion. Depends on urm_pkg and urm_div.
//
// One tick word is taken per microsecond tick and gives exactly one report
// word. A plain tick passes through accept, dispatch and finish. The start tick
// and the tick on which the echo falls also use the shared 17-step restoring
// divider and the shared multiplier, the echo fall multiplying first:
// the start tick works out floor(2*max/speed)*1000 for the echo wait limit,
// the falling edge works out width*speed/2000 mm, clamped to the maximum.
// tick_ready is high only while the sequencer is idle; a finished report
// waits in the output register and the next tick may be taken meanwhile.
// Registers sit at byte address 0 (max_distance_mm) and 4 (sound_speed_mps).
module ultrasonic_range_meter_core #(
  parameter int COUNT_WIDTH   = urm_pkg::COUNT_WIDTH_DEF,
  parameter int TRIGGER_TICKS = urm_pkg::TRIGGER_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // tick channel
  input  logic                            tick_valid,
  output logic                            tick_ready,
  input  logic                            start_request,
  input  logic                            echo_level,
  // report channel
  output logic                            rpt_valid,
  input  logic                            rpt_ready,
  output logic                            trigger_level,
  output logic                            result_valid,
  output logic [urm_pkg::DIST_W-1:0]      distance_mm,
  output logic                            timed_out,
  output logic                            busy_res,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [urm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [urm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [urm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int DW   = urm_pkg::DIST_W;
  localparam int SW   = urm_pkg::SPEED_W;
  localparam int TW   = urm_pkg::TRIG_CNT_W;
  localparam int QW   = urm_pkg::QUOT_W;
  localparam int MA_W = (COUNT_WIDTH > QW) ? COUNT_WIDTH : QW;
  localparam int PRW  = MA_W + SW;

  // configuration registers
  logic [DW-1:0] max_distance_mm;
  logic [SW-1:0] sound_speed_mps;
  logic          cfg_wr;

  // measurement state
  urm_pkg::phase_t        phase, phase_next;
  logic [TW-1:0]          trigger_count, trigger_count_next;
  logic [COUNT_WIDTH-1:0] elapsed_us, elapsed_us_next;
  logic [COUNT_WIDTH-1:0] timeout_us, timeout_us_next;

  // sequencer and latched tick
  urm_pkg::seq_t seq, seq_next;
  logic          start_lat;
  logic          echo_lat;
  logic          job_dist;
  logic          need_tmo;
  logic          need_dist;
  logic          div_start;
  logic          mul_en;
  logic          commit;
  logic          out_free;
  logic          accept;

  // shared arithmetic
  logic [PRW-1:0]                   prod;
  logic [MA_W-1:0]                  mul_a;
  logic [SW-1:0]                    mul_b;
  logic [PRW-1:0]                   div_dividend;
  logic [urm_pkg::DIVISOR_W-1:0]    div_divisor;
  logic [QW-1:0]                    quot;
  urm_pkg::div_stat_t               div_stat;

  // tick results
  logic                   res_trig;
  logic                   res_valid;
  logic [DW-1:0]          res_dist;
  logic                   res_tmo;
  logic [COUNT_WIDTH-1:0] elapsed_inc;
  logic [TW-1:0]          trig_inc;
  logic [COUNT_WIDTH-1:0] tmo_val;
  logic [DW-1:0]          dist_val;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance_mm <= urm_pkg::MAX_DIST_RST;
      sound_speed_mps <= urm_pkg::SPEED_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == urm_pkg::REG_SPEED) begin
        sound_speed_mps <= pwdata[SW-1:0];
      end else begin
        max_distance_mm <= pwdata[DW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == urm_pkg::REG_SPEED) begin
      prdata = urm_pkg::APB_DATA_W'(sound_speed_mps);
    end else begin
      prdata = urm_pkg::APB_DATA_W'(max_distance_mm);
    end
  end

  // tick handshake
  assign tick_ready = (seq == urm_pkg::SQ_IDLE);
  assign accept     = tick_valid && tick_ready;
  assign out_free   = !rpt_valid || rpt_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      start_lat <= start_request;
      echo_lat  <= echo_level;
    end
  end

  // work needed by this tick
  assign need_tmo  = (phase == urm_pkg::PH_IDLE) && start_lat;
  assign need_dist = (phase == urm_pkg::PH_MEAS) && !echo_lat;

  always_ff @(posedge clk) begin
    if (seq == urm_pkg::SQ_EXEC) begin
      job_dist <= need_dist;
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= urm_pkg::SQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  // sequencer next state
  always_comb begin
    seq_next = seq;
    case (seq)
      urm_pkg::SQ_IDLE: begin
        if (accept) begin
          seq_next = urm_pkg::SQ_EXEC;
        end
      end
      urm_pkg::SQ_EXEC: begin
        if (need_tmo) begin
          seq_next = urm_pkg::SQ_DIVGO;
        end else if (need_dist) begin
          seq_next = urm_pkg::SQ_MUL;
        end else begin
          seq_next = urm_pkg::SQ_FIN;
        end
      end
      urm_pkg::SQ_DIVGO: begin
        seq_next = urm_pkg::SQ_DIVWT;
      end
      urm_pkg::SQ_DIVWT: begin
        if (div_stat.done) begin
          seq_next = job_dist ? urm_pkg::SQ_FIN : urm_pkg::SQ_MUL;
        end
      end
      urm_pkg::SQ_MUL: begin
        seq_next = job_dist ? urm_pkg::SQ_DIVGO : urm_pkg::SQ_FIN;
      end
      urm_pkg::SQ_FIN: begin
        if (out_free) begin
          seq_next = urm_pkg::SQ_IDLE;
        end
      end
      default: begin
        seq_next = urm_pkg::SQ_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_start = 1'b0;
    mul_en    = 1'b0;
    commit    = 1'b0;
    case (seq)
      urm_pkg::SQ_DIVGO: div_start = 1'b1;
      urm_pkg::SQ_MUL:   mul_en    = 1'b1;
      urm_pkg::SQ_FIN:   commit    = out_free;
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // shared multiplier: width * speed, or quotient * 1000
  assign mul_a = job_dist ? MA_W'(elapsed_us) : MA_W'(quot);
  assign mul_b = job_dist ? sound_speed_mps : urm_pkg::US_PER_MS;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PRW'(mul_a) * PRW'(mul_b);
    end
  end

  // shared divider: product / 2000, or 2*max / speed
  assign div_dividend = job_dist ? prod : PRW'({max_distance_mm, 1'b0});
  assign div_divisor  = job_dist ? urm_pkg::ROUND_TRIP_K
                                 : urm_pkg::DIVISOR_W'(sound_speed_mps);

  urm_div #(
    .DIVIDEND_W (PRW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (quot),
    .stat     (div_stat)
  );

  // saturated echo wait limit and clamped distance
  assign tmo_val  = (div_stat.ovf || (|prod[PRW-1:COUNT_WIDTH])) ? '1
                                                                 : prod[COUNT_WIDTH-1:0];
  assign dist_val = (div_stat.ovf || (quot > QW'(max_distance_mm))) ? max_distance_mm
                                                                    : quot[DW-1:0];

  assign elapsed_inc = (elapsed_us == '1) ? elapsed_us : elapsed_us + 1'b1;
  assign trig_inc    = trigger_count + 1'b1;

  // per-tick phase step
  always_comb begin
    phase_next         = phase;
    trigger_count_next = trigger_count;
    elapsed_us_next    = elapsed_us;
    timeout_us_next    = timeout_us;
    res_trig           = 1'b0;
    res_valid          = 1'b0;
    res_dist           = '0;
    res_tmo            = 1'b0;
    case (phase)
      urm_pkg::PH_IDLE: begin
        if (start_lat) begin
          timeout_us_next    = tmo_val;
          trigger_count_next = TW'(1);
          res_trig           = 1'b1;
          elapsed_us_next    = '0;
          phase_next         = (TRIGGER_TICKS <= 1) ? urm_pkg::PH_WAIT : urm_pkg::PH_TRIG;
        end
      end
      urm_pkg::PH_TRIG: begin
        trigger_count_next = trig_inc;
        res_trig           = 1'b1;
        if ((trig_inc >= TW'(TRIGGER_TICKS)) || (trig_inc == '0)) begin
          elapsed_us_next = '0;
          phase_next      = urm_pkg::PH_WAIT;
        end
      end
      urm_pkg::PH_WAIT: begin
        if (echo_lat) begin
          elapsed_us_next = COUNT_WIDTH'(1);
          phase_next      = urm_pkg::PH_MEAS;
        end else begin
          elapsed_us_next = elapsed_inc;
          if (elapsed_inc > timeout_us) begin
            res_valid  = 1'b1;
            res_tmo    = 1'b1;
            res_dist   = max_distance_mm;
            phase_next = urm_pkg::PH_IDLE;
          end
        end
      end
      urm_pkg::PH_MEAS: begin
        if (echo_lat) begin
          elapsed_us_next = elapsed_inc;
        end else begin
          res_dist   = dist_val;
          res_valid  = 1'b1;
          phase_next = urm_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = urm_pkg::PH_IDLE;
      end
    endcase
  end

  // state commit when the report word is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= urm_pkg::PH_IDLE;
      trigger_count <= '0;
      elapsed_us    <= '0;
      timeout_us    <= '0;
    end else if (commit) begin
      phase         <= phase_next;
      trigger_count <= trigger_count_next;
      elapsed_us    <= elapsed_us_next;
      timeout_us    <= timeout_us_next;
    end
  end

  // report output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (commit) begin
      rpt_valid <= 1'b1;
    end else if (rpt_ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      trigger_level <= res_trig;
      result_valid  <= res_valid;
      distance_mm   <= res_dist;
      timed_out     <= res_tmo;
      busy_res      <= (phase_next != urm_pkg::PH_IDLE);
    end
  end

  // a new report word only comes out of the finish step
  a_rpt_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rpt_valid) |-> $past(seq == urm_pkg::SQ_FIN))
    else $error("report word loaded outside finish step");

  // a finished measurement leaves the block idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && result_valid) |-> !busy_res)
    else $error("finished measurement still reports busy");

  // reported distance never exceeds the maximum, timeout reports the maximum
  a_dist_clamped: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && result_valid) |-> (distance_mm <= max_distance_mm))
    else $error("distance above maximum");

  a_tmo_is_max: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && timed_out) |-> (result_valid && (distance_mm == max_distance_mm)))
    else $error("timeout word without maximum distance");

  // the sequencer only waits on a divider that is running
  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (seq == urm_pkg::SQ_DIVWT) |-> div_stat.busy)
    else $error("waiting on idle divider");

endmodule

// File: sim/ultrasonic_range_meter_core_test.sv
// Testbench for ultrasonic_range_meter_core: tick words in, report words out,
// each report compared with an in-bench model of the ranging controller or a table entry.
// Depends on urm_pkg and the core RTL only.
`timescale 1ns / 100ps

module ultrasonic_range_meter_core_test;

  localparam int CW = urm_pkg::COUNT_WIDTH_DEF;
  localparam int TT = urm_pkg::TRIGGER_TICKS_DEF;
  localparam logic [63:0] CNT_MAX = (64'd1 << CW) - 64'd1;
  localparam int PHASE_ITEMS = 200;
  localparam int NOISE_LEAD = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 50;
  localparam int NUM_PHASES = 9;

  // one report word as the core returns it
  typedef struct packed {
    logic                       trig;
    logic                       valid;
    logic [urm_pkg::DIST_W-1:0] dist_mm;
    logic                       tmo;
    logic                       busy;
  } report_t;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  // directed row: a register write or a run of identical tick words
  typedef struct packed {
    row_kind_t         kind;
    logic              idx;
    logic [31:0]       value;
    logic              start;
    logic              echo;
    logic [3:0]        rep;
    logic              typed;
    report_t           want;
  } row_t;

  localparam int NUM_ROWS = 10;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    // idle tick, echo ignored, all zero after reset
    '{ROW_TICK, urm_pkg::REG_MAX_DIST, 32'd0, 1'b0, 1'b1, 4'd1, 1'b1,
      '{1'b0, 1'b0, 16'd0, 1'b0, 1'b0}},
    // start tick is the first trigger tick
    '{ROW_TICK, urm_pkg::REG_MAX_DIST, 32'd0, 1'b1, 1'b0, 4'd1, 1'b1,
      '{1'b1, 1'b0, 16'd0, 1'b0, 1'b1}},
    // rest of the trigger pulse, start and echo ignored
    '{ROW_TICK, urm_pkg::REG_MAX_DIST, 32'd0, 1'b1, 1'b1, 4'd9, 1'b1,
      '{1'b1, 1'b0, 16'd0, 1'b0, 1'b1}},
    // echo rise on the first wait tick
    '{ROW_TICK, urm_pkg::REG_MAX_DIST, 32'd0, 1'b0, 1'b1, 4'd1, 1'b1,
      '{1'b0, 1'b0, 16'd0, 1'b0, 1'b1}},
    // echo held high, start ignored while busy
    '{ROW_TICK, urm_pkg::REG_MAX_DIST, 32'd0, 1'b1, 1'b1, 4'd2, 1'b1,
      '{1'b0, 1'b0, 16'd0, 1'b0, 1'b1}},
    // echo fall gives the distance
    '{ROW_TICK, urm_pkg::REG_MAX_DIST, 32'd0, 1'b0, 1'b0, 4'd1, 1'b0, '0},
    // max distance zero, upper bits masked off
    '{ROW_REG, urm_pkg::REG_MAX_DIST, 32'hFFFF_0000, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    // top speed, upper bits masked off
    '{ROW_REG, urm_pkg::REG_SPEED, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'd0, 1'b0, '0},
    // start plus trigger pulse
    '{ROW_TICK, urm_pkg::REG_MAX_DIST, 32'd0, 1'b1, 1'b0, 4'd10, 1'b1,
      '{1'b1, 1'b0, 16'd0, 1'b0, 1'b1}},
    // zero wait limit: first low wait tick times out at max
    '{ROW_TICK, urm_pkg::REG_MAX_DIST, 32'd0, 1'b0, 1'b0, 4'd1, 1'b1,
      '{1'b0, 1'b1, 16'd0, 1'b1, 1'b0}}
  };

  logic clk;
  logic rst = 1'b1;
  logic tick_valid = 1'b0;
  logic tick_ready;
  logic start_request = 1'b0;
  logic echo_level = 1'b0;
  logic rpt_valid;
  logic rpt_ready = 1'b0;
  logic trigger_level;
  logic result_valid;
  logic [urm_pkg::DIST_W-1:0] distance_mm;
  logic timed_out;
  logic busy_res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [urm_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [urm_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [urm_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  // model state and register copies
  urm_pkg::phase_t                meter_phase = urm_pkg::PH_IDLE;
  logic [urm_pkg::TRIG_CNT_W-1:0] trig_ticks = '0;
  logic [CW-1:0]                  echo_us = '0;
  logic [CW-1:0]                  echo_limit_us = '0;
  logic [urm_pkg::DIST_W-1:0]     cfg_max_mm = urm_pkg::MAX_DIST_RST;
  logic [urm_pkg::SPEED_W-1:0]    cfg_speed = urm_pkg::SPEED_RST;

  report_t reports_due [$];
  int mismatches = 0;
  int idle_send = 17;
  int idle_recv = 79;
  int idle_mode = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  report_t due_word;

  ultrasonic_range_meter_core dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // saturating echo counter step
  function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] v);
    return (64'(v) >= CNT_MAX) ? v : v + 1'b1;
  endfunction

  // echo wait limit for the current registers
  function automatic logic [CW-1:0] wait_limit();
    logic [63:0] t;
    if (cfg_speed == '0) return CNT_MAX[CW-1:0];
    t = ((64'(cfg_max_mm) * 64'd2) / 64'(cfg_speed)) * 64'(urm_pkg::US_PER_MS);
    return (t > CNT_MAX) ? CNT_MAX[CW-1:0] : t[CW-1:0];
  endfunction

  // advance the model by one tick word and return its report word
  function automatic report_t meter_tick(logic s, logic e);
    report_t r;
    logic [63:0] d;
    r = '0;
    case (meter_phase)
      urm_pkg::PH_IDLE: if (s) begin
        echo_limit_us = wait_limit();
        trig_ticks = urm_pkg::TRIG_CNT_W'(1);
        r.trig = 1'b1;
        echo_us = '0;
        if (TT <= 1) meter_phase = urm_pkg::PH_WAIT;
        else meter_phase = urm_pkg::PH_TRIG;
      end
      urm_pkg::PH_TRIG: begin
        trig_ticks = trig_ticks + 1'b1;
        r.trig = 1'b1;
        if (trig_ticks >= TT || trig_ticks == '0) begin
          echo_us = '0;
          meter_phase = urm_pkg::PH_WAIT;
        end
      end
      urm_pkg::PH_WAIT: if (e) begin
        echo_us = CW'(1);
        meter_phase = urm_pkg::PH_MEAS;
      end else begin
        echo_us = sat_inc(echo_us);
        if (echo_us > echo_limit_us) begin
          r.valid = 1'b1;
          r.tmo = 1'b1;
          r.dist_mm = cfg_max_mm;
          meter_phase = urm_pkg::PH_IDLE;
        end
      end
      default: if (e) begin
        echo_us = sat_inc(echo_us);
      end else begin
        d = (64'(echo_us) * 64'(cfg_speed)) / 64'(urm_pkg::ROUND_TRIP_K);
        if (d > 64'(cfg_max_mm)) d = 64'(cfg_max_mm);
        r.dist_mm = d[urm_pkg::DIST_W-1:0];
        r.valid = 1'b1;
        meter_phase = urm_pkg::PH_IDLE;
      end
    endcase
    r.busy = (meter_phase != urm_pkg::PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // offer one tick word, hold it until taken, then queue its report
  task automatic offer_tick(input logic s, input logic e, input logic typed,
                            input report_t want);
    report_t p;
    while ($urandom_range(0, 99) < idle_send) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    start_request <= s;
    echo_level <= e;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
    p = meter_tick(s, e);
    reports_due.push_back(typed ? want : p);
  endtask

  // one apb transfer, select left high for a following transfer
  task automatic apb_access(input logic wr, input logic idx,
                            input logic [urm_pkg::APB_DATA_W-1:0] wdata,
                            output logic [urm_pkg::APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  // write a register once the core has drained, then read it back
  task automatic write_reg(input logic idx,
                           input logic [urm_pkg::APB_DATA_W-1:0] value);
    logic [urm_pkg::APB_DATA_W-1:0] stored;
    logic [urm_pkg::APB_DATA_W-1:0] rdata;
    tick_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    if (idx == urm_pkg::REG_MAX_DIST) begin
      cfg_max_mm = value[urm_pkg::DIST_W-1:0];
      stored = urm_pkg::APB_DATA_W'(cfg_max_mm);
    end else begin
      cfg_speed = value[urm_pkg::SPEED_W-1:0];
      stored = urm_pkg::APB_DATA_W'(cfg_speed);
    end
    apb_access(1'b1, idx, value, rdata);
    apb_access(1'b0, idx, '0, rdata);
    check_field(idx == urm_pkg::REG_MAX_DIST ? "max_distance_mm read"
                                             : "sound_speed_mps read",
                stored, rdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: check each report word, random stalls, one long hold
  always @(posedge clk) begin
    if (!rst && rpt_valid && rpt_ready) begin
      if (reports_due.size() == 0) begin
        mismatches++;
        $display("%0t: report word with nothing pending", $time);
      end else begin
        due_word = reports_due.pop_front();
        check_field("trigger_level", 32'(due_word.trig), 32'(trigger_level));
        check_field("result_valid", 32'(due_word.valid), 32'(result_valid));
        check_field("distance_mm", 32'(due_word.dist_mm), 32'(distance_mm));
        check_field("timed_out", 32'(due_word.tmo), 32'(timed_out));
        check_field("busy_res", 32'(due_word.busy), 32'(busy_res));
      end
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      rpt_ready <= 1'b0;
    end else if (idle_mode == 2 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rpt_ready <= 1'b0;
    end else begin
      rpt_ready <= ($urandom_range(0, 99) >= idle_recv);
    end
  end

  // stimulus
  initial begin
    int n;
    int p;
    logic s;
    logic e;
    logic [CW-1:0] lim;
    logic [urm_pkg::DIST_W-1:0] mx;
    logic [urm_pkg::SPEED_W-1:0] sp;
    int unsigned rise_after_us;
    int unsigned width_target_us;
    rise_after_us = 0;
    width_target_us = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_REG)
        write_reg(DIRECTED[i].idx, DIRECTED[i].value);
      else
        repeat (DIRECTED[i].rep)
          offer_tick(DIRECTED[i].start, DIRECTED[i].echo, DIRECTED[i].typed,
                     DIRECTED[i].want);
    end

    // random phases, each under its own register setting, the idling mix changed every third phase
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin mx = urm_pkg::MAX_DIST_RST; sp = urm_pkg::SPEED_RST; end
        1: begin mx = 16'd0; sp = 10'd1023; end
        2: begin mx = 16'hFFFF; sp = 10'd0; end
        3: begin mx = 16'd1; sp = 10'd1023; end
        4: begin mx = 16'hFFFF; sp = 10'd1023; end
        5: begin mx = 16'd600; sp = 10'd1000; end
        default: begin
          mx = urm_pkg::DIST_W'($urandom_range(0, 65535));
          sp = urm_pkg::SPEED_W'($urandom_range(0, 1023));
        end
      endcase
      write_reg(urm_pkg::REG_MAX_DIST, {16'($urandom), mx});
      write_reg(urm_pkg::REG_SPEED, {22'($urandom), sp});
      idle_mode = p / 3;
      case (idle_mode)
        0: begin idle_send = 17; idle_recv = 79; end
        1: begin idle_send = 79; idle_recv = 17; end
        default: begin idle_send = 0; idle_recv = 0; end
      endcase

      n = 0;
      while (n < PHASE_ITEMS || meter_phase != urm_pkg::PH_IDLE) begin
        s = 1'b0;
        e = 1'($urandom_range(0, 1));
        // well-formed measurement driven off the model phase
        case (meter_phase)
          urm_pkg::PH_IDLE: if ($urandom_range(0, 2) == 0) begin
            s = 1'b1;
            lim = wait_limit();
            if (lim == '0)
              rise_after_us = $urandom_range(0, 1);
            else if (lim <= 1000 && $urandom_range(0, 7) == 0)
              rise_after_us = lim + 1;
            else
              rise_after_us = $urandom_range(0, (lim < 30) ? lim : 30);
            if ($urandom_range(0, 29) == 0)
              width_target_us = $urandom_range(1, 1200);
            else
              width_target_us = $urandom_range(1, 40);
          end
          urm_pkg::PH_TRIG: s = 1'($urandom_range(0, 1));
          urm_pkg::PH_WAIT: begin
            s = 1'($urandom_range(0, 1));
            e = (echo_us >= rise_after_us);
          end
          default: begin
            s = 1'($urandom_range(0, 1));
            e = (echo_us < width_target_us);
          end
        endcase
        // noise and broken sequences
        if (n < NOISE_LEAD || $urandom_range(0, 11) == 0) begin
          s = 1'($urandom_range(0, 1));
          e = 1'($urandom_range(0, 1));
        end
        offer_tick(s, e, 1'b0, '0);
        n++;
      end
    end

    // drain and finish
    tick_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // run limit
  initial begin
    #(20_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
